FILE: sv/tfd_pkg.sv
// ----------------------------------------------------------------------------
// tfd_pkg
// Shared types and constants for the telemetry frame deframer.
// ----------------------------------------------------------------------------
package tfd_pkg;

    localparam int FRAME_BUFFER_SIZE_DEF = 32;

    localparam logic [7:0]  SYNC_FIRST    = 8'h4D;
    localparam logic [7:0]  SYNC_SECOND   = 8'h50;
    localparam logic [7:0]  TYPE_A        = 8'h02;
    localparam logic [7:0]  TYPE_B        = 8'h03;
    localparam logic [7:0]  MIN_LENGTH    = 8'd9;
    localparam logic [15:0] HEADER_WORD   = 16'h1098;
    localparam logic [15:0] ID_LINK       = 16'hF101;
    localparam logic [15:0] ID_BATTERY    = 16'hF104;
    localparam logic [15:0] ID_AUX        = 16'hF103;
    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

    localparam logic       REQ_BYTE = 1'b0;
    localparam logic       REQ_TICK = 1'b1;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_LINK    = 2'd1;
    localparam logic [1:0] KIND_BATTERY = 2'd2;
    localparam logic [1:0] KIND_AUX     = 2'd3;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } tfd_in_t;

    typedef struct packed {
        logic       packet_ok;
        logic [1:0] sensor_kind;
        logic [7:0] rssi_receive;
        logic [7:0] rssi_transmit;
        logic [7:0] lqi_receive;
        logic [7:0] lqi_transmit;
        logic [7:0] battery_level;
        logic [7:0] aux_analog;
        logic       timed_out;
    } tfd_out_t;

endpackage

FILE: sv/telemetry_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// telemetry_frame_deframer_core
// Resynchronizing telemetry deframer with link-loss timeout.
//
// Input beats carry either a received serial byte or a one millisecond tick.
// Bytes are framed as 'M' 'P' type length body; an accepted packet updates
// the held RSSI/LQI, battery or aux analog values. Ticks count the time
// since the last accepted packet and raise a sticky timeout flag once the
// count reaches the timeout register.
// Every input beat produces exactly one output beat with the held values.
// Each beat passes through the input register and then the output register.
// Throughput: one beat per cycle while the receiver does not stall, set by
// the single pass of framer logic between the input and output registers.
// Reset clears the framer, held values, timer and flag, and loads the
// timeout register with 2000. While the receiver stalls, the output beat
// holds; the input register takes at most one more beat, and in_stall stays
// high while it is full. The user must write the timeout register
// through cfg_wen/cfg_wdata only when idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module telemetry_frame_deframer_core
    import tfd_pkg::*;
#(
    parameter int FRAME_BUFFER_SIZE = FRAME_BUFFER_SIZE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  tfd_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output tfd_out_t    out_data,
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata
);

    localparam int POS_W = $clog2(FRAME_BUFFER_SIZE);
    localparam logic [POS_W:0] POS_LIMIT = (POS_W + 1)'(FRAME_BUFFER_SIZE);
    localparam logic [POS_W-1:0] POS_IDLE = '0;
    localparam logic [POS_W-1:0] POS_SYNC = (POS_W)'(1);
    localparam logic [POS_W-1:0] POS_TYPE = (POS_W)'(2);
    localparam logic [POS_W-1:0] POS_LEN  = (POS_W)'(3);
    localparam logic [POS_W-1:0] POS_BODY = (POS_W)'(4);

    logic              stage_valid_reg;
    tfd_in_t           stage_reg;
    logic              out_valid_reg;
    tfd_out_t          out_reg;
    logic [15:0]       timeout_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [7:0]        remaining_reg;
    logic [7:0]        remaining_next;
    logic [7:0]        type_reg;
    logic [7:0]        type_next;
    logic [7:0]        length_reg;
    logic [7:0]        length_next;
    logic [7:0]        payload_reg [8];
    logic [7:0]        link_reg [4];
    logic [7:0]        link_next [4];
    logic [7:0]        battery_reg;
    logic [7:0]        battery_next;
    logic [7:0]        aux_reg;
    logic [7:0]        aux_next;
    logic [15:0]       ms_reg;
    logic [15:0]       ms_next;
    logic              flag_reg;
    logic              flag_next;

    logic              advance;
    logic              store_en;
    logic [2:0]        store_slot;
    logic [POS_W:0]    pos_inc;
    logic [POS_W-1:0]  slot_full;
    logic [7:0]        c;
    logic [1:0]        kind;
    logic [15:0]       header;
    logic [15:0]       source_id;

    assign advance   = stage_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = stage_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign c         = stage_reg.rx_byte;
    assign header    = {payload_reg[1], payload_reg[0]};
    assign source_id = {payload_reg[3], payload_reg[2]};
    assign pos_inc   = {1'b0, pos_reg} + (POS_W + 1)'(1);
    assign slot_full = pos_reg - POS_BODY;

    always_comb
    begin
        pos_next       = pos_reg;
        remaining_next = remaining_reg;
        type_next      = type_reg;
        length_next    = length_reg;
        link_next      = link_reg;
        battery_next   = battery_reg;
        aux_next       = aux_reg;
        ms_next        = ms_reg;
        flag_next      = flag_reg;
        kind           = KIND_NONE;
        store_en       = 1'b0;
        store_slot     = slot_full[2:0];

        if (stage_reg.req_type == REQ_TICK)
        begin
            if (ms_reg != 16'hFFFF)
            begin
                ms_next = ms_reg + 16'd1;
            end
        end
        else if (pos_reg == POS_IDLE)
        begin
            remaining_next = '0;
            if (c == SYNC_FIRST)
            begin
                pos_next = POS_SYNC;
            end
        end
        else if (pos_reg == POS_SYNC && c == SYNC_FIRST)
        begin
            remaining_next = '0;
        end
        else if (pos_reg == POS_SYNC && c == SYNC_SECOND)
        begin
            remaining_next = '0;
            pos_next       = POS_TYPE;
        end
        else if (pos_reg == POS_TYPE)
        begin
            type_next      = c;
            remaining_next = '0;
            pos_next       = POS_LEN;
        end
        else if (pos_reg == POS_LEN)
        begin
            length_next    = c;
            remaining_next = c;
            pos_next       = POS_BODY;
        end
        else if (remaining_reg != '0)
        begin
            store_en       = (slot_full < (POS_W)'(8));
            remaining_next = remaining_reg - 8'd1;
            pos_next       = pos_inc[POS_W-1:0];
            if (remaining_reg == 8'd1 && (type_reg == TYPE_A || type_reg == TYPE_B)
                && length_reg >= MIN_LENGTH && header == HEADER_WORD)
            begin
                if (source_id == ID_LINK)
                begin
                    kind         = KIND_LINK;
                    link_next[0] = payload_reg[4];
                    link_next[1] = payload_reg[5];
                    link_next[2] = payload_reg[6];
                    link_next[3] = payload_reg[7];
                end
                else if (source_id == ID_BATTERY)
                begin
                    kind         = KIND_BATTERY;
                    battery_next = payload_reg[4];
                end
                else if (source_id == ID_AUX)
                begin
                    kind     = KIND_AUX;
                    aux_next = payload_reg[4];
                end
            end
            if (kind != KIND_NONE)
            begin
                ms_next   = '0;
                flag_next = 1'b0;
                pos_next  = POS_IDLE;
            end
            else if (pos_inc >= POS_LIMIT)
            begin
                remaining_next = '0;
                pos_next       = (c == SYNC_FIRST) ? POS_SYNC : POS_IDLE;
            end
        end
        else
        begin
            remaining_next = '0;
            pos_next       = (c == SYNC_FIRST) ? POS_SYNC : POS_IDLE;
        end

        if (ms_next >= timeout_reg)
        begin
            flag_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            timeout_reg     <= TIMEOUT_RESET;
            pos_reg         <= '0;
            remaining_reg   <= '0;
            type_reg        <= '0;
            length_reg      <= '0;
            link_reg        <= '{default: '0};
            battery_reg     <= '0;
            aux_reg         <= '0;
            ms_reg          <= '0;
            flag_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                timeout_reg <= cfg_wdata;
            end
            if (!in_stall)
            begin
                stage_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                pos_reg       <= pos_next;
                remaining_reg <= remaining_next;
                type_reg      <= type_next;
                length_reg    <= length_next;
                link_reg      <= link_next;
                battery_reg   <= battery_next;
                aux_reg       <= aux_next;
                ms_reg        <= ms_next;
                flag_reg      <= flag_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            stage_reg <= in_data;
        end
        if (advance)
        begin
            if (store_en)
            begin
                payload_reg[store_slot] <= c;
            end
            out_reg.packet_ok     <= (kind != KIND_NONE);
            out_reg.sensor_kind   <= kind;
            out_reg.rssi_receive  <= link_next[0];
            out_reg.rssi_transmit <= link_next[1];
            out_reg.lqi_receive   <= link_next[2];
            out_reg.lqi_transmit  <= link_next[3];
            out_reg.battery_level <= battery_next;
            out_reg.aux_analog    <= aux_next;
            out_reg.timed_out     <= flag_next;
        end
    end

endmodule
